>>> src/nnva_pkg.sv
// nnva_pkg: shared types and constants for the nearest neighbor variance acquisition block
// no dependencies; imported by nnva_acq, nearest_neighbor_variance_acquisition and the testbench

package nnva_pkg;

    localparam int VAL_W    = 24;
    localparam int SPREAD_W = 23;
    localparam int ACQ_W    = 63;
    localparam int NEAR_W   = 8;
    localparam int SQ_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD_COORD = 2'd0,
        OP_LOAD_REF   = 2'd1,
        OP_LOAD_TEST  = 2'd2,
        OP_QUERY      = 2'd3
    } op_t;

    typedef struct packed {
        logic                    go;
        logic signed [VAL_W-1:0] mean;
        logic [SPREAD_W-1:0]     spread;
        logic signed [VAL_W-1:0] ref_value;
    } acq_req_t;

    typedef struct packed {
        logic             done;
        logic [ACQ_W-1:0] acquisition;
    } acq_rsp_t;

endpackage

>>> src/nnva_acq.sv
// nnva_acq: computes 4*var*bias^2 + 2*var^2 as var*(4*bias^2 + 2*var), Q.16 result
// depends on nnva_pkg; four partial products of a shared multiplier, one per cycle

module nnva_acq
    import nnva_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  acq_req_t req,
    output acq_rsp_t rsp
);

    localparam int VAR_W  = 2 * SPREAD_W;
    localparam int VL_W   = VAR_W / 2;
    localparam int VH_W   = VAR_W - VL_W;
    localparam int S_W    = SQ_W + 3;
    localparam int SL_W   = (S_W + 1) / 2;
    localparam int PP_W   = VH_W + SL_W;
    localparam int PROD_W = VAR_W + S_W;
    localparam int DROP_W = 48;
    localparam int KEEP_W = PROD_W - DROP_W;
    localparam logic [2:0] LAST_STEP = 3'd4;

    typedef enum logic [1:0] {A_IDLE, A_SUM, A_MUL} state_t;

    state_t              state_reg;
    logic [2:0]          step_reg;
    logic [1:0]          pp_sel_reg;
    logic                done_reg;
    logic [ACQ_W-1:0]    acq_reg;
    logic [VAR_W-1:0]    var_reg;
    logic [SQ_W-1:0]     b2_reg;
    logic [S_W-1:0]      s_reg;
    logic [PP_W-1:0]     pp_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic signed [VAL_W:0]     bias;
    logic signed [2*VAL_W+1:0] bias_sq;
    logic [VAR_W-1:0]          var_prod;
    logic [VH_W-1:0]           var_part;
    logic [SL_W-1:0]           s_part;
    logic [PP_W-1:0]           pp_next;
    logic [PROD_W-1:0]         pp_shift;
    logic [PROD_W-1:0]         prod_next;

    assign bias     = {req.mean[VAL_W-1], req.mean} - {req.ref_value[VAL_W-1], req.ref_value};
    assign bias_sq  = bias * bias;
    assign var_prod = VAR_W'(req.spread) * VAR_W'(req.spread);

    assign var_part = step_reg[1] ? VH_W'(var_reg[VAR_W-1:VL_W]) : VH_W'(var_reg[VL_W-1:0]);
    assign s_part   = step_reg[0] ? SL_W'(s_reg[S_W-1:SL_W]) : s_reg[SL_W-1:0];
    assign pp_next  = PP_W'(var_part) * PP_W'(s_part);

    always_comb
    begin
        case (pp_sel_reg)
            2'd0:    pp_shift = PROD_W'(pp_reg);
            2'd1:    pp_shift = PROD_W'(pp_reg) << SL_W;
            2'd2:    pp_shift = PROD_W'(pp_reg) << VL_W;
            default: pp_shift = PROD_W'(pp_reg) << (VL_W + SL_W);
        endcase
    end

    assign prod_next = prod_reg + pp_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (req.go)
                    begin
                        state_reg <= A_SUM;
                    end
                end
                A_SUM:
                begin
                    step_reg  <= '0;
                    state_reg <= A_MUL;
                end
                A_MUL:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == A_IDLE && req.go)
        begin
            var_reg <= var_prod;
            b2_reg  <= bias_sq[SQ_W-1:0];
        end
        if (state_reg == A_SUM)
        begin
            s_reg    <= S_W'({b2_reg, 2'b00}) + S_W'({var_reg, 1'b0});
            prod_reg <= '0;
        end
        if (state_reg == A_MUL)
        begin
            if (step_reg != LAST_STEP)
            begin
                pp_reg     <= pp_next;
                pp_sel_reg <= step_reg[1:0];
            end
            if (step_reg != 3'd0)
            begin
                prod_reg <= prod_next;
            end
            if (step_reg == LAST_STEP)
            begin
                // product stays below 2^97, so the Q.16 value never reaches saturation
                acq_reg <= ACQ_W'(prod_next[PROD_W-1:PROD_W-KEEP_W]);
            end
        end
    end

    assign rsp.done        = done_reg;
    assign rsp.acquisition = acq_reg;

endmodule

>>> src/nearest_neighbor_variance_acquisition.sv
// nearest_neighbor_variance_acquisition: training store, nearest point scan, acquisition value
// depends on nnva_pkg and nnva_acq
//
// channel   | direction | handshake            | payload
// request   | in        | start, busy          | operation, point_index, dim_index, value, spread
// result    | out       | done (one cycle)     | acquisition, nearest_index
// config    | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// loads leave busy low
// a query holds busy while the scan reads one coordinate per cycle from the coordinate memory,
// then while the acquisition value goes through a four step shared multiplier
// reset clears control state and sets both counts to 1; the memories start undefined
// results cannot be stalled; done is high for exactly one cycle per query

module nearest_neighbor_variance_acquisition
    import nnva_pkg::*;
#(
    parameter int MAX_TRAIN = 256,
    parameter int MAX_DIM   = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              operation,
    input  logic [7:0]              point_index,
    input  logic [2:0]              dim_index,
    input  logic signed [VAL_W-1:0] value,
    input  logic [SPREAD_W-1:0]     spread,
    output logic                    done,
    output logic [ACQ_W-1:0]        acquisition,
    output logic [NEAR_W-1:0]       nearest_index,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data
);

    localparam int IW     = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
    localparam int DW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_TRAIN * (2 ** DW);
    localparam int SUM_W  = SQ_W + DW;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_REF, S_CALC, S_WAIT} state_t;

    state_t            state_reg;
    logic [8:0]        train_count_reg;
    logic [3:0]        dim_count_reg;
    logic [IW-1:0]     nt_last_reg;
    logic [DW-1:0]     nd_last_reg;
    logic [IW-1:0]     pi_reg;
    logic [DW-1:0]     dj_reg;
    logic              rd_v_reg;
    logic              rd_first_reg;
    logic              rd_last_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              sq_v_reg;
    logic              sq_first_reg;
    logic              sq_last_reg;
    logic [IW-1:0]     sq_idx_reg;
    logic              dist_v_reg;
    logic [IW-1:0]     dist_idx_reg;
    logic [IW-1:0]     best_i_reg;
    logic [NEAR_W-1:0] nearest_reg;

    logic signed [VAL_W-1:0] coord_mem [DEPTH];
    logic signed [VAL_W-1:0] ref_mem [MAX_TRAIN];
    logic signed [VAL_W-1:0] test_mem [MAX_DIM];

    logic signed [VAL_W-1:0]  coord_rd_reg;
    logic signed [VAL_W-1:0]  test_rd_reg;
    logic signed [VAL_W-1:0]  ref_rd_reg;
    logic signed [VAL_W-1:0]  mean_reg;
    logic [SPREAD_W-1:0]      spread_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SUM_W-1:0]         acc_reg;
    logic [SUM_W-1:0]         dist_reg;
    logic [SUM_W-1:0]         best_reg;

    logic              accept;
    logic [12:0]       pi_ext;
    logic [4:0]        di_ext;
    logic              pi_ok;
    logic              di_ok;
    logic [IW-1:0]     load_pi;
    logic [DW-1:0]     load_dj;
    logic [12:0]       tc_ext;
    logic [4:0]        dc_ext;
    logic [IW-1:0]     nt_last;
    logic [DW-1:0]     nd_last;
    logic signed [VAL_W:0]     diff;
    logic signed [2*VAL_W+1:0] diff_sq;
    logic [SUM_W-1:0]  sum_next;
    logic              take_best;
    logic              dim_end;

    acq_req_t acq_req;
    acq_rsp_t acq_rsp;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign pi_ext  = 13'(point_index);
    assign di_ext  = 5'(dim_index);
    assign pi_ok   = (pi_ext < 13'(MAX_TRAIN));
    assign di_ok   = (di_ext < 5'(MAX_DIM));
    assign load_pi = IW'(pi_ext);
    assign load_dj = DW'(di_ext);

    assign tc_ext = 13'(train_count_reg);
    assign dc_ext = 5'(dim_count_reg);

    always_comb
    begin
        if (tc_ext == 13'd0)
        begin
            nt_last = '0;
        end
        else if (tc_ext > 13'(MAX_TRAIN))
        begin
            nt_last = IW'(MAX_TRAIN - 1);
        end
        else
        begin
            nt_last = IW'(tc_ext - 13'd1);
        end

        if (dc_ext == 5'd0)
        begin
            nd_last = '0;
        end
        else if (dc_ext > 5'(MAX_DIM))
        begin
            nd_last = DW'(MAX_DIM - 1);
        end
        else
        begin
            nd_last = DW'(dc_ext - 5'd1);
        end
    end

    assign dim_end   = (dj_reg == nd_last_reg);
    assign diff      = {test_rd_reg[VAL_W-1], test_rd_reg} - {coord_rd_reg[VAL_W-1], coord_rd_reg};
    assign diff_sq   = diff * diff;
    assign sum_next  = (sq_first_reg ? '0 : acc_reg) + SUM_W'(sq_reg);
    // later index wins on equal distance
    assign take_best = dist_v_reg && (dist_idx_reg == '0 || dist_reg <= best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            train_count_reg <= 9'd1;
            dim_count_reg   <= 4'd1;
            nt_last_reg     <= '0;
            nd_last_reg     <= '0;
            pi_reg          <= '0;
            dj_reg          <= '0;
            rd_v_reg        <= 1'b0;
            rd_first_reg    <= 1'b0;
            rd_last_reg     <= 1'b0;
            rd_idx_reg      <= '0;
            sq_v_reg        <= 1'b0;
            sq_first_reg    <= 1'b0;
            sq_last_reg     <= 1'b0;
            sq_idx_reg      <= '0;
            dist_v_reg      <= 1'b0;
            dist_idx_reg    <= '0;
            best_i_reg      <= '0;
            nearest_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TRAIN_COUNT)
                begin
                    train_count_reg <= cfg_data;
                end
                else if (cfg_index == REG_DIM_COUNT)
                begin
                    dim_count_reg <= cfg_data[3:0];
                end
            end

            rd_v_reg     <= 1'b0;
            rd_first_reg <= (dj_reg == '0);
            rd_last_reg  <= dim_end;
            rd_idx_reg   <= pi_reg;
            sq_v_reg     <= rd_v_reg;
            sq_first_reg <= rd_first_reg;
            sq_last_reg  <= rd_last_reg;
            sq_idx_reg   <= rd_idx_reg;
            dist_v_reg   <= sq_v_reg && sq_last_reg;
            dist_idx_reg <= sq_idx_reg;
            if (take_best)
            begin
                best_i_reg <= dist_idx_reg;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && operation == OP_QUERY)
                    begin
                        pi_reg      <= '0;
                        dj_reg      <= '0;
                        nt_last_reg <= nt_last;
                        nd_last_reg <= nd_last;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    rd_v_reg <= 1'b1;
                    if (dim_end)
                    begin
                        dj_reg <= '0;
                        pi_reg <= pi_reg + IW'(1);
                        if (pi_reg == nt_last_reg)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                    else
                    begin
                        dj_reg <= dj_reg + DW'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_v_reg && !sq_v_reg && !dist_v_reg)
                    begin
                        state_reg <= S_REF;
                    end
                end
                S_REF:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    nearest_reg <= NEAR_W'(best_i_reg);
                    state_reg   <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (acq_rsp.done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_LOAD_COORD && pi_ok && di_ok)
        begin
            coord_mem[{load_pi, load_dj}] <= value;
        end
        coord_rd_reg <= coord_mem[{pi_reg, dj_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_LOAD_REF && pi_ok)
        begin
            ref_mem[load_pi] <= value;
        end
        ref_rd_reg <= ref_mem[best_i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_LOAD_TEST && di_ok)
        begin
            test_mem[load_dj] <= value;
        end
        test_rd_reg <= test_mem[dj_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_QUERY)
        begin
            mean_reg   <= value;
            spread_reg <= spread;
        end
        sq_reg <= diff_sq[SQ_W-1:0];
        if (sq_v_reg)
        begin
            acc_reg <= sum_next;
        end
        dist_reg <= sum_next;
        if (take_best)
        begin
            best_reg <= dist_reg;
        end
    end

    assign acq_req.go        = (state_reg == S_CALC);
    assign acq_req.mean      = mean_reg;
    assign acq_req.spread    = spread_reg;
    assign acq_req.ref_value = ref_rd_reg;

    nnva_acq u_acq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (acq_req),
        .rsp   (acq_rsp)
    );

    assign done          = acq_rsp.done;
    assign acquisition   = acq_rsp.acquisition;
    assign nearest_index = nearest_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe outside a query");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_QUERY) |=> busy)
        else $error("query request did not start a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation != OP_QUERY) |=> !busy)
        else $error("load request made the block busy");

endmodule

>>> tb/nearest_neighbor_variance_acquisition_tb.sv
// nearest_neighbor_variance_acquisition_tb: self-checking bench for the nearest point scan
// and variance acquisition result; queued requests, random idling, in-bench predictor
// depends on nnva_pkg and nearest_neighbor_variance_acquisition

module nearest_neighbor_variance_acquisition_tb;
    import nnva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TRAIN     = 256;
    localparam int NUM_DIM       = 8;
    localparam int DRAIN_CAP     = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam int NUM_PHASES    = 6;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

    localparam logic [VAL_W-1:0]    VAL_MAX    = 24'h7FFFFF;
    localparam logic [VAL_W-1:0]    VAL_MIN    = 24'h800000;
    localparam logic [VAL_W-1:0]    VAL_ONE    = 24'h010000;
    localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;
    localparam logic [127:0]        ACQ_LIMIT  = {65'd0, {63{1'b1}}};

    typedef struct {
        op_t                 op;
        logic [7:0]          point;
        logic [2:0]          dim;
        logic [VAL_W-1:0]    val;
        logic [SPREAD_W-1:0] sd;
    } request_t;

    typedef struct packed {
        logic [ACQ_W-1:0]  acquisition;
        logic [NEAR_W-1:0] nearest_index;
    } answer_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              operation = '0;
    logic [7:0]              point_index = '0;
    logic [2:0]              dim_index = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic [SPREAD_W-1:0]     spread = '0;
    logic                    done;
    logic [ACQ_W-1:0]        acquisition;
    logic [NEAR_W-1:0]       nearest_index;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DAT_W-1:0]    cfg_data = '0;

    request_t pending_requests[$];
    answer_t  expected_answers[$];

    // predictor state
    logic [VAL_W-1:0] coord_mem [NUM_TRAIN*NUM_DIM];
    logic [VAL_W-1:0] ref_mem [NUM_TRAIN];
    logic [VAL_W-1:0] test_mem [NUM_DIM];
    logic [8:0]       train_reg = 9'd1;
    logic [3:0]       dim_reg = 4'd1;

    // which entries the queued stimulus has written so far
    bit coord_loaded [NUM_TRAIN*NUM_DIM];
    bit ref_loaded [NUM_TRAIN];
    bit test_loaded [NUM_DIM];
    int gen_train = 1;
    int gen_dim = 1;

    logic req_taken = 1'b0;
    int   gap_pct = 0;
    int   gap_left = 0;
    int   error_count = 0;
    int   queries_sent = 0;
    int   loads_sent = 0;
    int   results_checked = 0;

    always #1 clk = ~clk;

    nearest_neighbor_variance_acquisition dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .point_index   (point_index),
        .dim_index     (dim_index),
        .value         (value),
        .spread        (spread),
        .done          (done),
        .acquisition   (acquisition),
        .nearest_index (nearest_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int clamp_count(int v, int top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic logic [63:0] sq_gap(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        longint da;
        longint db;
        longint d;
        da = longint'($signed(a));
        db = longint'($signed(b));
        d = da - db;
        if (d < 0)
            d = -d;
        return d * d;
    endfunction

    function automatic answer_t predict_acquisition(logic [VAL_W-1:0] mean,
                                                    logic [SPREAD_W-1:0] sd);
        int           n_train;
        int           n_dim;
        int           i;
        int           j;
        int           best_i;
        logic [63:0]  distance;
        logic [63:0]  best;
        logic [127:0] variance;
        logic [127:0] bias_sq;
        logic [127:0] total;
        logic [127:0] scaled;
        answer_t      ans;
        n_train = clamp_count(train_reg, NUM_TRAIN);
        n_dim = clamp_count(dim_reg, NUM_DIM);
        best = '0;
        best_i = 0;
        for (i = 0; i < n_train; i++)
        begin
            distance = '0;
            for (j = 0; j < n_dim; j++)
                distance += sq_gap(test_mem[j], coord_mem[i*NUM_DIM + j]);
            // later index wins on equal distance
            if (i == 0 || distance <= best)
            begin
                best = distance;
                best_i = i;
            end
        end
        variance = sd;
        variance = variance * variance;
        bias_sq = sq_gap(mean, ref_mem[best_i]);
        total = 4 * variance * bias_sq + 2 * variance * variance;
        scaled = total >> 48;
        ans.acquisition = (scaled > ACQ_LIMIT) ? ACQ_LIMIT[ACQ_W-1:0] : scaled[ACQ_W-1:0];
        ans.nearest_index = NEAR_W'(best_i);
        return ans;
    endfunction

    always @(negedge clk)
    begin : drive_requests
        request_t item;
        if (rst_n)
        begin
            if (start && !req_taken)
            begin
                // hold the request until accepted
            end
            else if (gap_left != 0)
            begin
                start <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                item = pending_requests.pop_front();
                operation <= item.op;
                point_index <= item.point;
                dim_index <= item.dim;
                value <= item.val;
                spread <= item.sd;
                start <= 1'b1;
                if (gap_pct != 0 && $urandom_range(99) < gap_pct)
                    gap_left = $urandom_range(16, 1);
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : sample_ports
        answer_t want;
        if (rst_n)
        begin
            req_taken <= start && !busy;
            if (done)
            begin
                results_checked++;
                if (expected_answers.size() == 0)
                    report_mismatch("result with no query outstanding");
                else
                begin
                    want = expected_answers.pop_front();
                    if (acquisition !== want.acquisition)
                        report_mismatch($sformatf("acquisition %h, expected %h",
                                                  acquisition, want.acquisition));
                    if (nearest_index !== want.nearest_index)
                        report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                                  nearest_index, want.nearest_index));
                end
            end
            if (start && !busy)
            begin
                case (op_t'(operation))
                    OP_LOAD_COORD: coord_mem[point_index*NUM_DIM + dim_index] = value;
                    OP_LOAD_REF:   ref_mem[point_index] = value;
                    OP_LOAD_TEST:  test_mem[dim_index] = value;
                    OP_QUERY:      expected_answers.push_back(predict_acquisition(value, spread));
                    default: ;
                endcase
                if (op_t'(operation) == OP_QUERY)
                    queries_sent++;
                else
                    loads_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TRAIN_COUNT: train_reg = cfg_data;
                    REG_DIM_COUNT:   dim_reg = cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    task automatic queue_request(op_t op, logic [7:0] point, logic [2:0] dim,
                                 logic [VAL_W-1:0] val, logic [SPREAD_W-1:0] sd);
        request_t item;
        item.op = op;
        item.point = point;
        item.dim = dim;
        item.val = val;
        item.sd = sd;
        pending_requests.push_back(item);
        case (op)
            OP_LOAD_COORD: coord_loaded[point*NUM_DIM + dim] = 1'b1;
            OP_LOAD_REF:   ref_loaded[point] = 1'b1;
            OP_LOAD_TEST:  test_loaded[dim] = 1'b1;
            default: ;
        endcase
    endtask

    // half of the time full range, else extremes or a small pool so that distances tie
    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2, 3: return VAL_W'(($urandom_range(4) * 32'h10000) - 32'h20000);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [SPREAD_W-1:0] random_spread();
        case ($urandom_range(7))
            0: return '0;
            1: return SPREAD_MAX;
            2, 3: return SPREAD_W'($urandom_range(32'h40000));
            default: return SPREAD_W'($urandom);
        endcase
    endfunction

    task automatic fill_active();
        int i;
        int j;
        for (i = 0; i < gen_train; i++)
        begin
            for (j = 0; j < gen_dim; j++)
                if (!coord_loaded[i*NUM_DIM + j])
                    queue_request(OP_LOAD_COORD, 8'(i), 3'(j), random_value(),
                                  SPREAD_W'($urandom));
            if (!ref_loaded[i])
                queue_request(OP_LOAD_REF, 8'(i), 3'($urandom), random_value(), '0);
        end
        for (j = 0; j < gen_dim; j++)
            if (!test_loaded[j])
                queue_request(OP_LOAD_TEST, 8'($urandom), 3'(j), random_value(), '0);
    endtask

    task automatic random_phase(int count);
        int kind;
        repeat (count)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
                queue_request(OP_QUERY, 8'($urandom), 3'($urandom), random_value(),
                              random_spread());
            else if (kind < 70)
                queue_request(OP_LOAD_COORD, 8'($urandom_range(gen_train - 1)),
                              3'($urandom_range(gen_dim - 1)), random_value(),
                              SPREAD_W'($urandom));
            else if (kind < 80)
                queue_request(OP_LOAD_REF, 8'($urandom_range(gen_train - 1)),
                              3'($urandom), random_value(), SPREAD_W'($urandom));
            else if (kind < 90)
                queue_request(OP_LOAD_TEST, 8'($urandom), 3'($urandom_range(gen_dim - 1)),
                              random_value(), SPREAD_W'($urandom));
            else
                queue_request(op_t'($urandom_range(2)), 8'($urandom), 3'($urandom),
                              random_value(), SPREAD_W'($urandom));
        end
    endtask

    // wait until every queued request is sent and every query has answered, or until DRAIN_CAP is reached
    task automatic drain();
        int waited;
        waited = 0;
        do
        begin
            @(posedge clk);
            if (pending_requests.size() == 0 && !start)
                waited++;
        end
        while ((pending_requests.size() != 0 || start || busy ||
                expected_answers.size() != 0) && waited < DRAIN_CAP);
        if (waited >= DRAIN_CAP)
        begin
            report_mismatch($sformatf("%0d queries never answered", expected_answers.size()));
            expected_answers.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_counts(int n_train, int n_dim);
        write_reg(REG_TRAIN_COUNT, CFG_DAT_W'(n_train));
        write_reg(REG_DIM_COUNT, CFG_DAT_W'(n_dim));
        gen_train = clamp_count(n_train, NUM_TRAIN);
        gen_dim = clamp_count(n_dim, NUM_DIM);
    endtask

    initial
    begin : stimulus
        int phase_train [NUM_PHASES];
        int phase_dim [NUM_PHASES];
        int phase_gap [NUM_PHASES];
        int phase_size [NUM_PHASES];
        int p;
        int i;
        int j;
        phase_train = '{4, 0, 40, 5, 2, 7};
        phase_dim   = '{3, 0, 1, 8, 15, 2};
        phase_gap   = '{25, 0, 40, 30, 20, 0};
        phase_size  = '{30, 15, 25, 25, 20, 30};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset counts: one point, one dimension
        gap_pct = 25;
        queue_request(OP_LOAD_COORD, 8'd0, 3'd0, VAL_MAX, SPREAD_MAX);
        queue_request(OP_LOAD_REF, 8'd0, 3'd0, '0, '0);
        queue_request(OP_LOAD_TEST, 8'd0, 3'd0, VAL_MIN, '0);
        queue_request(OP_QUERY, 8'hFF, 3'h7, VAL_MAX, SPREAD_MAX);
        queue_request(OP_QUERY, 8'h00, 3'h0, VAL_MIN, SPREAD_MAX);
        queue_request(OP_QUERY, 8'h5A, 3'h2, VAL_MAX, '0);
        queue_request(OP_LOAD_REF, 8'd0, 3'd5, VAL_MIN, SPREAD_MAX);
        queue_request(OP_QUERY, 8'h00, 3'h0, VAL_MAX, SPREAD_MAX);
        queue_request(OP_LOAD_COORD, 8'd255, 3'd7, VAL_MIN, '0);
        queue_request(OP_LOAD_REF, 8'd255, 3'd0, VAL_MAX, '0);
        queue_request(OP_LOAD_TEST, 8'd255, 3'd7, VAL_MAX, '0);
        queue_request(OP_LOAD_TEST, 8'd0, 3'd0, VAL_MAX, '0);
        queue_request(OP_QUERY, 8'h00, 3'h0, VAL_W'(1), SPREAD_W'(1));
        queue_request(OP_QUERY, 8'hA5, 3'h5, '0, SPREAD_MAX);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p == 3)
            begin
                write_reg(REG_UNUSED_LO, CFG_DAT_W'($urandom_range(511)));
                write_reg(REG_UNUSED_HI, CFG_DAT_W'($urandom_range(511)));
            end
            set_counts(phase_train[p], phase_dim[p]);
            gap_pct = phase_gap[p];
            if (p == 0)
            begin
                // identical points: the last one must win
                for (i = 0; i < 4; i++)
                begin
                    for (j = 0; j < 3; j++)
                        queue_request(OP_LOAD_COORD, 8'(i), 3'(j), VAL_ONE, '0);
                    queue_request(OP_LOAD_REF, 8'(i), 3'd0, VAL_W'(i << 16), '0);
                end
                for (j = 0; j < 3; j++)
                    queue_request(OP_LOAD_TEST, 8'd0, 3'(j), VAL_ONE, '0);
                queue_request(OP_QUERY, 8'd0, 3'd0, VAL_MIN, SPREAD_MAX);
            end
            fill_active();
            random_phase(phase_size[p]);
        end
        drain();

        $display("sent %0d loads and %0d queries; %0d results checked over %0d count settings",
                 loads_sent, queries_sent, results_checked, NUM_PHASES + 1);
        $display("settings reached up to 40 points and 8 dimensions, zero and oversized counts too");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
